// File: rtl/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types and constants of the multilevel task selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ets_pkg;

  localparam int SLOTS  = 64;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DL_W   = 31;
  localparam int TIME_W = 32;
  localparam int CHAN_W = 32;
  localparam int META_W = 4;

  localparam logic [DL_W-1:0]   INITIAL_DEADLINE = DL_W'(1000000000);
  localparam logic [TIME_W-1:0] AGING_RESET      = TIME_W'(100);

  typedef enum logic [3:0] {
    CMD_CREATE   = 4'd0,
    CMD_RUNNABLE = 4'd1,
    CMD_BLOCK    = 4'd2,
    CMD_WAKE     = 4'd3,
    CMD_DEADLINE = 4'd4,
    CMD_LEVEL    = 4'd5,
    CMD_TICK     = 4'd6,
    CMD_PICK     = 4'd7,
    CMD_RELEASE  = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_RUNNABLE = 2'd2,
    ST_RUNNING  = 2'd3
  } ent_st_e;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_AT_LVL  = 2'd1,
    RES_NOTHING = 2'd2
  } res_st_e;

  typedef enum logic [1:0] {
    CLS_RT   = 2'd0,
    CLS_RR   = 2'd1,
    CLS_FC   = 2'd2,
    CLS_NONE = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_APPLY,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_e;

  // Entry metadata word: level (1 = first come), real-time flag, status.
  typedef struct packed {
    logic    lv;
    logic    rt;
    ent_st_e st;
  } meta_t;

  localparam meta_t META_RESET = '{lv: 1'b1, rt: 1'b0, st: ST_UNUSED};

  typedef struct packed {
    logic load;
    logic lookup;
    logic scan;
    logic done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_scan;
    logic scan_last;
  } dp_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0] affected;
    logic [IDX_W-1:0] chosen;
    logic             valid;
    res_st_e          status;
  } result_t;

endpackage

// File: rtl/ets_ram.sv
// ----------------------------------------------------------------------------
// ets_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/ets_ctrl.sv
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer: single-entry lookup and apply, or a sweep over the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ets_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ets_pkg::dp_stat_t  stat_i,
  output logic               idle_o,
  output ets_pkg::ctrl_cmd_t cmd_o
);
  import ets_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          state_d = stat_i.is_scan ? S_SCAN : S_LOOKUP;
        end
      end
      S_LOOKUP: state_d = S_APPLY;
      S_APPLY:  state_d = S_IDLE;
      S_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_FIN;
      S_FIN:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idle_o      = (state_q == S_IDLE);
    cmd_o       = '0;
    cmd_o.load  = (state_q == S_IDLE) && accept_i;
    cmd_o.lookup = (state_q == S_LOOKUP);
    cmd_o.scan  = (state_q == S_SCAN);
    cmd_o.done  = (state_q == S_APPLY) || (state_q == S_FIN);
  end

endmodule

// File: rtl/ets_dp.sv
// ----------------------------------------------------------------------------
// ets_dp
// Task table, class counters, round-robin pointer and scan datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ets_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ets_pkg::ctrl_cmd_t         cmd_i,
  output ets_pkg::dp_stat_t          stat_o,
  input  logic [3:0]                 in_cmd_i,
  input  logic [5:0]                 in_slot_i,
  input  logic [1:0]                 in_level_i,
  input  logic [ets_pkg::CHAN_W-1:0] in_chan_i,
  input  logic [ets_pkg::DL_W-1:0]   in_dl_i,
  input  logic [ets_pkg::TIME_W-1:0] in_now_i,
  input  logic [ets_pkg::TIME_W-1:0] thr_i,
  output ets_pkg::result_t           res_o
);
  import ets_pkg::*;

  function automatic logic [2:0] cls_oh(input logic rt, input logic lv);
    logic [2:0] r;
    r = 3'b000;
    if (rt) begin
      r[CLS_RT] = 1'b1;
    end else if (lv) begin
      r[CLS_FC] = 1'b1;
    end else begin
      r[CLS_RR] = 1'b1;
    end
    return r;
  endfunction

  logic [3:0]        cmd_q;
  logic [5:0]        slot_q;
  logic [1:0]        lvl_q;
  logic [CHAN_W-1:0] chan_q;
  logic [DL_W-1:0]   dl_q;
  logic [TIME_W-1:0] now_q;

  logic [SLOTS-1:0]  vld_q;
  logic              mvld_q;
  logic [IDX_W-1:0]  k_q, pidx_q, best_q, rr_ptr_q;
  logic              proc_q, found_q, found_d;
  logic [IDX_W-1:0]  best_d;
  logic [TIME_W-1:0] key_q, key_d;
  meta_t             bmeta_q, bmeta_d;
  cls_e              pcls_q;
  logic [CNT_W-1:0]  aff_q, aff_d;
  logic [CNT_W-1:0]  cnt_q [3];
  logic [2:0]        up, dn;

  logic [IDX_W-1:0]  raddr, waddr;
  logic [META_W-1:0] meta_rd;
  meta_t             e, meta_wd;
  logic              meta_we, arr_we, dl_we, chan_we;
  logic [TIME_W-1:0] arr_rd;
  logic [DL_W-1:0]   dl_rd, dl_wd;
  logic [CHAN_W-1:0] chan_rd;
  logic              in_range, is_pick;
  logic [TIME_W-1:0] waited;
  logic              tgt;

  assign is_pick  = (cmd_q == CMD_PICK);
  assign in_range = (32'(slot_q) < 32'(SLOTS));
  assign e        = mvld_q ? meta_t'(meta_rd) : META_RESET;
  assign waited   = now_q - arr_rd;
  assign tgt      = (lvl_q == 2'd2);

  always_comb begin
    raddr = slot_q[IDX_W-1:0];
    if (cmd_i.scan) begin
      raddr = ((is_pick && pcls_q == CLS_RR) ? rr_ptr_q : '0) + k_q;
    end
  end

  assign stat_o.is_scan   = (in_cmd_i == CMD_WAKE) || (in_cmd_i == CMD_TICK) ||
                            (in_cmd_i == CMD_PICK);
  assign stat_o.scan_last = (k_q == IDX_W'(SLOTS - 1));

  ets_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
    .clk_i, .we_i(meta_we), .waddr_i(waddr), .wdata_i(meta_wd),
    .raddr_i(raddr), .rdata_o(meta_rd)
  );
  ets_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_arr (
    .clk_i, .we_i(arr_we), .waddr_i(waddr), .wdata_i(now_q),
    .raddr_i(raddr), .rdata_o(arr_rd)
  );
  ets_ram #(.WIDTH(DL_W), .DEPTH(SLOTS)) u_dl (
    .clk_i, .we_i(dl_we), .waddr_i(waddr), .wdata_i(dl_wd),
    .raddr_i(raddr), .rdata_o(dl_rd)
  );
  ets_ram #(.WIDTH(CHAN_W), .DEPTH(SLOTS)) u_chan (
    .clk_i, .we_i(chan_we), .waddr_i(waddr), .wdata_i(chan_q),
    .raddr_i(raddr), .rdata_o(chan_rd)
  );

  always_comb begin
    meta_we = 1'b0;
    arr_we  = 1'b0;
    dl_we   = 1'b0;
    chan_we = 1'b0;
    waddr   = slot_q[IDX_W-1:0];
    meta_wd = e;
    dl_wd   = dl_q;
    up      = 3'b000;
    dn      = 3'b000;
    found_d = found_q;
    best_d  = best_q;
    key_d   = key_q;
    bmeta_d = bmeta_q;
    aff_d   = aff_q;
    res_o   = '0;

    // Sweep commands: metadata of entry pidx_q was read during the scan.
    if (proc_q) begin
      waddr = pidx_q;
      if (cmd_q == CMD_WAKE) begin
        if (e.st == ST_SLEEPING && chan_rd == chan_q) begin
          meta_we    = 1'b1;
          meta_wd.st = ST_RUNNABLE;
          arr_we     = 1'b1;
          up         = cls_oh(e.rt, e.lv);
          aff_d      = aff_q + 1'b1;
        end
      end else if (cmd_q == CMD_TICK) begin
        if (e.st == ST_RUNNABLE && !e.rt && e.lv && waited >= thr_i) begin
          meta_we    = 1'b1;
          meta_wd.lv = 1'b0;
          arr_we     = 1'b1;
          dn[CLS_FC] = 1'b1;
          up[CLS_RR] = 1'b1;
          aff_d      = aff_q + 1'b1;
        end
      end else begin
        priority case (pcls_q)
          CLS_RT: begin
            if (e.st == ST_RUNNABLE && e.rt &&
                (!found_q || TIME_W'(dl_rd) < key_q)) begin
              found_d = 1'b1;
              best_d  = pidx_q;
              key_d   = TIME_W'(dl_rd);
              bmeta_d = e;
            end
          end
          CLS_RR: begin
            if (!found_q && e.st == ST_RUNNABLE && !e.rt && !e.lv) begin
              found_d = 1'b1;
              best_d  = pidx_q;
              bmeta_d = e;
            end
          end
          CLS_FC: begin
            if (e.st == ST_RUNNABLE && !e.rt && e.lv &&
                (!found_q || arr_rd < key_q)) begin
              found_d = 1'b1;
              best_d  = pidx_q;
              key_d   = arr_rd;
              bmeta_d = e;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd_i.done && (cmd_q == CMD_WAKE || cmd_q == CMD_TICK ||
                                cmd_q == CMD_PICK)) begin
      res_o.affected = aff_q;
      if (is_pick) begin
        if (found_q) begin
          waddr        = best_q;
          meta_we      = 1'b1;
          meta_wd      = bmeta_q;
          meta_wd.st   = ST_RUNNING;
          dn           = cls_oh(bmeta_q.rt, bmeta_q.lv);
          res_o.valid  = 1'b1;
          res_o.chosen = best_q;
        end else begin
          res_o.status = RES_NOTHING;
        end
      end
    end else if (cmd_i.done && in_range) begin
      unique case (cmd_q)
        CMD_CREATE: begin
          if (e.st == ST_UNUSED) begin
            meta_we = 1'b1;
            meta_wd = '{lv: (lvl_q != 2'd1), rt: 1'b0, st: ST_RUNNABLE};
            dl_we   = 1'b1;
            dl_wd   = INITIAL_DEADLINE;
            arr_we  = 1'b1;
            up      = cls_oh(1'b0, lvl_q != 2'd1);
          end
        end
        CMD_RUNNABLE: begin
          if (e.st == ST_RUNNING || e.st == ST_SLEEPING) begin
            meta_we    = 1'b1;
            meta_wd.st = ST_RUNNABLE;
            arr_we     = 1'b1;
            up         = cls_oh(e.rt, e.lv);
          end
        end
        CMD_BLOCK: begin
          if (e.st != ST_UNUSED) begin
            chan_we    = 1'b1;
            meta_we    = 1'b1;
            meta_wd.st = ST_SLEEPING;
            if (e.st == ST_RUNNABLE) begin
              dn = cls_oh(e.rt, e.lv);
            end
          end
        end
        CMD_DEADLINE: begin
          if (e.st != ST_UNUSED) begin
            if (e.st == ST_RUNNABLE && !e.rt) begin
              dn         = cls_oh(1'b0, e.lv);
              up[CLS_RT] = 1'b1;
            end
            meta_we    = 1'b1;
            meta_wd.rt = 1'b1;
            dl_we      = 1'b1;
          end
        end
        CMD_LEVEL: begin
          if (e.st != ST_UNUSED && (lvl_q == 2'd1 || lvl_q == 2'd2)) begin
            if (e.rt) begin
              meta_we    = 1'b1;
              meta_wd.lv = tgt;
            end else if (e.lv == tgt) begin
              res_o.status = RES_AT_LVL;
            end else begin
              meta_we    = 1'b1;
              meta_wd.lv = tgt;
              if (e.st == ST_RUNNABLE) begin
                dn = cls_oh(1'b0, e.lv);
                up = cls_oh(1'b0, tgt);
              end
            end
          end
        end
        CMD_RELEASE: begin
          if (e.st != ST_UNUSED) begin
            if (e.st == ST_RUNNABLE) begin
              dn = cls_oh(e.rt, e.lv);
            end
            meta_we = 1'b1;
            meta_wd = META_RESET;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_cmd_i;
      slot_q <= in_slot_i;
      lvl_q  <= in_level_i;
      chan_q <= in_chan_i;
      dl_q   <= in_dl_i;
      now_q  <= in_now_i;
    end
    mvld_q  <= vld_q[raddr];
    pidx_q  <= raddr;
    best_q  <= best_d;
    key_q   <= key_d;
    bmeta_q <= bmeta_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      k_q      <= '0;
      proc_q   <= 1'b0;
      found_q  <= 1'b0;
      aff_q    <= '0;
      pcls_q   <= CLS_NONE;
      rr_ptr_q <= '0;
      for (int c = 0; c < 3; c++) begin
        cnt_q[c] <= '0;
      end
    end else begin
      if (meta_we) begin
        vld_q[waddr] <= 1'b1;
      end
      proc_q <= cmd_i.scan;
      if (cmd_i.load) begin
        k_q     <= '0;
        found_q <= 1'b0;
        aff_q   <= '0;
        if (cnt_q[CLS_RT] != '0) begin
          pcls_q <= CLS_RT;
        end else if (cnt_q[CLS_RR] != '0) begin
          pcls_q <= CLS_RR;
        end else if (cnt_q[CLS_FC] != '0) begin
          pcls_q <= CLS_FC;
        end else begin
          pcls_q <= CLS_NONE;
        end
      end else begin
        if (cmd_i.scan) begin
          k_q <= k_q + 1'b1;
        end
        found_q <= found_d;
        aff_q   <= aff_d;
      end
      if (cmd_i.done && is_pick && found_q && pcls_q == CLS_RR) begin
        rr_ptr_q <= best_q + 1'b1;
      end
      // Decrements saturate at zero; a class never moves both ways at once.
      for (int c = 0; c < 3; c++) begin
        if (dn[c] && cnt_q[c] != '0) begin
          cnt_q[c] <= cnt_q[c] - 1'b1;
        end else if (up[c]) begin
          cnt_q[c] <= cnt_q[c] + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/edf_rr_fcfs_task_selector.sv
// ----------------------------------------------------------------------------
// edf_rr_fcfs_task_selector
// Multilevel task selector: earliest deadline, round robin, first come.
// ----------------------------------------------------------------------------
// Channel     Dir  Handshake               Content
// s_axis      in   tvalid/tready           one command word
// m_axis      out  tvalid/tready           one result word per command
// apb         in   psel/penable/pready     aging threshold at address 0
//
// Addressed commands pass through accept, lookup read and apply into the
// result register. Wake, tick and pick sweep the 64-entry table through the
// RAM read port, one entry per cycle, between accept and the drain and
// finish steps.
// A new word is taken while the previous result is taken in the same cycle.
// Reset clears all entries through per-entry valid bits, with no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edf_rr_fcfs_task_selector (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // command[3:0], slot[9:4], level[11:10], channel[43:12],
  // deadline[74:44], now[106:75], zero fill[111:107]
  input  logic [111:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status[1:0], chosen_valid[2], chosen_slot[8:3], affected_count[15:9]
  output logic [15:0]   m_axis_tdata,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ets_pkg::*;

  logic              idle, accept;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  result_t           res;
  logic [TIME_W-1:0] thr_q;
  logic              out_valid_q;
  logic [15:0]       out_data_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? thr_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= AGING_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      thr_q <= pwdata;
    end
  end

  assign s_axis_tready = idle && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  ets_ctrl u_ctrl (
    .clk_i, .rst_ni, .accept_i(accept), .stat_i(stat), .idle_o(idle), .cmd_o(cmd)
  );

  ets_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .in_cmd_i(s_axis_tdata[3:0]), .in_slot_i(s_axis_tdata[9:4]),
    .in_level_i(s_axis_tdata[11:10]), .in_chan_i(s_axis_tdata[43:12]),
    .in_dl_i(s_axis_tdata[74:44]), .in_now_i(s_axis_tdata[106:75]),
    .thr_i(thr_q), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.done) begin
      out_data_q <= {res.affected, res.chosen, res.valid, res.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: dv/edf_rr_fcfs_task_selector_checker.sv
// ----------------------------------------------------------------------------
// edf_rr_fcfs_task_selector_checker
// Watches the command, result and register ports of the task selector,
// keeps its own copy of the task table and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edf_rr_fcfs_task_selector_checker
  import ets_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           outstanding,
  output int           picks_made,
  output int           tasks_affected
);

  localparam logic [2:0] REG_AGING = 3'd0;
  localparam logic [1:0] LVL_RR    = 2'd1;
  localparam logic [1:0] LVL_FC    = 2'd2;

  ent_st_e         task_st  [SLOTS];
  logic            task_rt  [SLOTS];
  logic            task_fc  [SLOTS];
  logic [DL_W-1:0] task_dl  [SLOTS];
  logic [31:0]     task_arr [SLOTS];
  logic [31:0]     task_chn [SLOTS];
  logic [IDX_W-1:0] rr_next;
  int              n_rt, n_rr, n_fc;
  logic [31:0]     aging_limit;
  result_t         expected_words[$];

  assign outstanding = expected_words.size();

  function automatic cls_e class_of(int i);
    if (task_rt[i]) return CLS_RT;
    return task_fc[i] ? CLS_FC : CLS_RR;
  endfunction

  task automatic adjust(cls_e c, int d);
    case (c)
      CLS_RT: begin
        if (d > 0 || n_rt > 0) n_rt += d;
      end
      CLS_RR: begin
        if (d > 0 || n_rr > 0) n_rr += d;
      end
      default: begin
        if (d > 0 || n_fc > 0) n_fc += d;
      end
    endcase
  endtask

  task automatic wake_entry(int i, logic [31:0] now);
    task_st[i]  = ST_RUNNABLE;
    task_arr[i] = now;
    adjust(class_of(i), 1);
  endtask

  task automatic schedule(input logic [111:0] w, output result_t r);
    logic [3:0]       cmd;
    int               s, best, k, idx;
    logic [1:0]       lvl;
    logic [31:0]      chan, now;
    logic [DL_W-1:0]  dl;
    logic             found, tgt;
    cmd   = w[3:0];
    s     = w[9:4];
    lvl   = w[11:10];
    chan  = w[43:12];
    dl    = w[74:44];
    now   = w[106:75];
    r     = '0;
    found = 1'b0;
    best  = 0;
    case (cmd)
      CMD_CREATE: begin
        if (task_st[s] == ST_UNUSED) begin
          task_rt[s] = 1'b0;
          task_fc[s] = (lvl != LVL_RR);
          task_dl[s] = INITIAL_DEADLINE;
          wake_entry(s, now);
        end
      end
      CMD_RUNNABLE: begin
        if (task_st[s] == ST_RUNNING || task_st[s] == ST_SLEEPING) wake_entry(s, now);
      end
      CMD_BLOCK: begin
        if (task_st[s] != ST_UNUSED) begin
          task_chn[s] = chan;
          if (task_st[s] == ST_RUNNABLE) adjust(class_of(s), -1);
          task_st[s] = ST_SLEEPING;
        end
      end
      CMD_WAKE: begin
        for (int i = 0; i < SLOTS; i++)
          if (task_st[i] == ST_SLEEPING && task_chn[i] == chan) begin
            wake_entry(i, now);
            r.affected++;
          end
      end
      CMD_DEADLINE: begin
        if (task_st[s] != ST_UNUSED) begin
          if (task_st[s] == ST_RUNNABLE && !task_rt[s]) begin
            adjust(class_of(s), -1);
            adjust(CLS_RT, 1);
          end
          task_rt[s] = 1'b1;
          task_dl[s] = dl;
        end
      end
      CMD_LEVEL: begin
        if (task_st[s] != ST_UNUSED && (lvl == LVL_RR || lvl == LVL_FC)) begin
          tgt = (lvl == LVL_FC);
          if (task_rt[s]) task_fc[s] = tgt;
          else if (task_fc[s] == tgt) r.status = RES_AT_LVL;
          else if (task_st[s] == ST_RUNNABLE) begin
            adjust(class_of(s), -1);
            task_fc[s] = tgt;
            adjust(class_of(s), 1);
          end else task_fc[s] = tgt;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (task_st[i] == ST_RUNNABLE && !task_rt[i] && task_fc[i] &&
              (now - task_arr[i]) >= aging_limit) begin
            adjust(CLS_FC, -1);
            task_fc[i] = 1'b0;
            adjust(CLS_RR, 1);
            task_arr[i] = now;
            r.affected++;
          end
      end
      CMD_PICK: begin
        if (n_rt > 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (task_st[i] == ST_RUNNABLE && task_rt[i] &&
                (!found || task_dl[i] < task_dl[best])) begin
              best  = i;
              found = 1'b1;
            end
        end else if (n_rr > 0) begin
          for (k = 0; k < SLOTS && !found; k++) begin
            idx = (rr_next + k) % SLOTS;
            if (task_st[idx] == ST_RUNNABLE && !task_rt[idx] && !task_fc[idx]) begin
              best    = idx;
              found   = 1'b1;
              rr_next = IDX_W'((idx + 1) % SLOTS);
            end
          end
        end else if (n_fc > 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (task_st[i] == ST_RUNNABLE && !task_rt[i] && task_fc[i] &&
                (!found || task_arr[i] < task_arr[best])) begin
              best  = i;
              found = 1'b1;
            end
        end
        if (found) begin
          adjust(class_of(best), -1);
          task_st[best] = ST_RUNNING;
          r.valid  = 1'b1;
          r.chosen = IDX_W'(best);
        end else r.status = RES_NOTHING;
      end
      CMD_RELEASE: begin
        if (task_st[s] != ST_UNUSED) begin
          if (task_st[s] == ST_RUNNABLE) adjust(class_of(s), -1);
          task_st[s] = ST_UNUSED;
          task_rt[s] = 1'b0;
          task_fc[s] = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, int want, int got);
    $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        task_st[i]  = ST_UNUSED;
        task_rt[i]  = 1'b0;
        task_fc[i]  = 1'b1;
        task_dl[i]  = '0;
        task_arr[i] = '0;
        task_chn[i] = '0;
      end
      rr_next        = '0;
      n_rt           = 0;
      n_rr           = 0;
      n_fc           = 0;
      aging_limit    = AGING_RESET;
      fail_count     = 0;
      picks_made     = 0;
      tasks_affected = 0;
      expected_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_words.size() == 0) begin
          $display("[%0t] result word with nothing pending", $realtime);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status) report("status", want.status, got.status);
          if (got.valid !== want.valid) report("chosen_valid", want.valid, got.valid);
          if (got.chosen !== want.chosen) report("chosen_slot", want.chosen, got.chosen);
          if (got.affected !== want.affected)
            report("affected_count", want.affected, got.affected);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        schedule(s_axis_tdata, want);
        picks_made     += want.valid;
        tasks_affected += want.affected;
        expected_words.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr == REG_AGING) aging_limit = pwdata;
    end
  end

endmodule

// File: dv/edf_rr_fcfs_task_selector_test.sv
// ----------------------------------------------------------------------------
// edf_rr_fcfs_task_selector_test
// Drives directed and random command words with random gaps and result
// stalls through several aging thresholds; the checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edf_rr_fcfs_task_selector_test;
  import ets_pkg::*;

  localparam logic [2:0] REG_AGING = 3'd0;
  localparam logic [1:0] LVL_RR    = 2'd1;
  localparam logic [1:0] LVL_FC    = 2'd2;
  localparam int         IDLE_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  int           fail_count, outstanding, picks_made, tasks_affected;
  int           words_sent = 0;
  int           idle_cycles = 0;
  int           stall_left = 0;
  bit           steady_sink = 1'b0;
  logic [31:0]  now_tick = '0;
  logic [31:0]  thresholds[5] = '{32'd0, 32'd5, 32'hFFFF_FFFF, 32'd30, 32'd100};

  always #5 clk_i = ~clk_i;

  edf_rr_fcfs_task_selector dut (.*);

  edf_rr_fcfs_task_selector_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .outstanding, .picks_made, .tasks_affected
  );

  // Result side: mostly short stalls, a few long ones, and quiet stretches.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_sink && $urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
                                                   : $urandom_range(1, 4);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results pending", outstanding);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(cmd_e cmd, int slot, logic [1:0] lvl, logic [31:0] chan,
                      logic [DL_W-1:0] dl, logic [31:0] now, bit gaps);
    int gap;
    s_axis_tdata  <= {5'b0, now, dl, chan, lvl, 6'(slot), 4'(cmd)};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    gap = 0;
    if (gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 24) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_raw(logic [3:0] code, bit gaps);
    send(cmd_e'(code), $urandom_range(0, 63), 2'($urandom), $urandom, 31'($urandom),
         $urandom, gaps);
  endtask

  task automatic drain_and_write(logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_AGING;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_word();
    int           pick, slot;
    logic [31:0]  chan;
    logic [DL_W-1:0] dl;
    cmd_e         cmd;
    pick = $urandom_range(0, 99);
    slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
    chan = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 3));
    dl   = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 50));
    if ($urandom_range(0, 49) == 0) now_tick = $urandom;
    else now_tick += $urandom_range(0, 12);
    if (pick < 3) begin
      send_raw(4'($urandom_range(9, 15)), 1'b1);
      return;
    end
    if (pick < 17)      cmd = CMD_CREATE;
    else if (pick < 27) cmd = CMD_RUNNABLE;
    else if (pick < 37) cmd = CMD_BLOCK;
    else if (pick < 45) cmd = CMD_WAKE;
    else if (pick < 52) cmd = CMD_DEADLINE;
    else if (pick < 62) cmd = CMD_LEVEL;
    else if (pick < 72) cmd = CMD_TICK;
    else if (pick < 93) cmd = CMD_PICK;
    else                cmd = CMD_RELEASE;
    send(cmd, slot, 2'($urandom), chan, dl, now_tick, !steady_sink);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: empty pick, each class, ties, extremes, ignored cases.
    send(CMD_PICK, 0, LVL_RR, 0, 0, 0, 0);
    send(CMD_CREATE, 63, LVL_FC, 0, 0, 32'hFFFF_FFFF, 0);
    send(CMD_CREATE, 63, LVL_RR, 0, 0, 0, 0);
    send(CMD_CREATE, 0, 2'd0, 0, 0, 32'd5, 0);
    send(CMD_CREATE, 5, LVL_RR, 0, 0, 32'd5, 0);
    send(CMD_CREATE, 6, 2'd3, 0, 0, 32'd5, 0);
    send(CMD_LEVEL, 5, LVL_RR, 0, 0, 0, 0);
    send(CMD_LEVEL, 5, 2'd3, 0, 0, 0, 0);
    send(CMD_LEVEL, 40, LVL_RR, 0, 0, 0, 0);
    send(CMD_DEADLINE, 0, 0, 0, 31'h7FFF_FFFF, 0, 0);
    send(CMD_DEADLINE, 6, 0, 0, 31'h7FFF_FFFF, 0, 0);
    send(CMD_DEADLINE, 30, 0, 0, 31'd0, 0, 0);
    send(CMD_LEVEL, 6, LVL_RR, 0, 0, 0, 0);
    send(CMD_PICK, 0, 0, 0, 0, 0, 0);
    send(CMD_PICK, 0, 0, 0, 0, 0, 0);
    send(CMD_PICK, 0, 0, 0, 0, 0, 0);
    send(CMD_TICK, 0, 0, 0, 0, 32'd4, 0);
    send(CMD_TICK, 0, 0, 0, 0, 32'd200, 0);
    send(CMD_BLOCK, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(CMD_BLOCK, 6, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(CMD_BLOCK, 20, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send(CMD_WAKE, 0, 0, 32'hFFFF_FFFF, 0, 32'd300, 0);
    send(CMD_RUNNABLE, 5, 0, 0, 0, 32'd301, 0);
    send(CMD_RELEASE, 63, 0, 0, 0, 0, 0);
    send_raw(4'd15, 0);

    foreach (thresholds[p]) begin
      drain_and_write(thresholds[p]);
      for (int n = 0; n < 260; n++) begin
        if (n % 100 == 0) steady_sink = ($urandom_range(0, 3) == 0);
        random_word();
      end
    end
    steady_sink = 1'b0;
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d command words over %0d aging thresholds.", words_sent,
             $size(thresholds));
    $display("Picks that chose a task: %0d; tasks woken or promoted: %0d.",
             picks_made, tasks_affected);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
